// ===== src/srle_pkg.sv =====
package srle_pkg;

  // Default geometry limit and queue depth between front and back
  localparam int SRLE_MAX_DIM    = 1023;
  localparam int SRLE_FIFO_DEPTH = 2;

  // Fixed field widths
  localparam int CODE_W  = 8;
  localparam int DIM_W   = 10;
  localparam int PIX_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 1'd1;

  // Register reset values
  localparam logic [DIM_W-1:0] SPRITE_WIDTH_RST  = 10'd8;
  localparam logic [DIM_W-1:0] SPRITE_HEIGHT_RST = 10'd8;

  // Operations handed from front to back
  typedef enum logic [1:0] {
    OP_LITERAL,
    OP_END_ROW,
    OP_SKIP
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CODE_W-1:0] data;   // literal value or skip distance (1..128)
  } op_t;

  // Configuration write beat
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
  } cfg_wr_t;

endpackage

// ===== src/sprite_row_rle_decoder.sv =====
// Sprite row run-length decoder.
// Throughput: one code byte per cycle while the queue has room; the front classifies
// a byte in its accept cycle. The accepting edge writes the op into the queue; the back
// later executes it into the output register once that register is free or draining.
// Run-opening bytes produce no queue entry. Output stalls back up through the 2-entry queue.
// Reset: synchronous active-low rst_n clears mode, counts, column, row, queue; width/height = 8.
module sprite_row_rle_decoder import srle_pkg::*; #(
  parameter int MAX_DIM = SRLE_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] code_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [9:0] pixel_x, [19:10] pixel_y, [27:20] pixel_value
  output logic                 out_tlast,  // sprite_done
  output logic [0:0]           out_tuser   // [0] is_pixel
);

  logic    q_full, q_push, q_valid, q_pop;
  op_t     q_in_op, q_out_op;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  srle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .in_tready (in_tready),
    .q_push    (q_push),
    .q_op      (q_in_op)
  );

  srle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_in_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_op    (q_out_op)
  );

  srle_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .op_valid   (q_valid),
    .op         (q_out_op),
    .op_pop     (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A result is either a pixel write or the done marker, never both
  a_pix_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] != out_tlast))
    else $error("result is both or neither pixel and done");

  // The done marker carries an all-zero payload
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == '0))
    else $error("done result with nonzero payload");

  // The queue only fills through an accepted byte
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("queue filled without an accepted byte");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

// ===== src/srle_front.sv =====
module srle_front import srle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [CODE_W-1:0] in_tdata,
  input  logic              q_full,
  output logic              in_tready,
  output logic              q_push,
  output op_t               q_op
);

  logic       lit_run_r, lit_run_nxt;
  logic [6:0] left_r, left_nxt;
  logic       accept;
  logic [6:0] left_dec;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign left_dec  = left_r - 7'd1;

  // Classify the byte and track the literal run
  always_comb begin
    lit_run_nxt = lit_run_r;
    left_nxt    = left_r;
    q_push      = 1'b0;
    q_op.kind   = OP_LITERAL;
    q_op.data   = in_tdata;
    if (accept) begin
      if (lit_run_r) begin
        q_push   = 1'b1;
        left_nxt = left_dec;
        if (left_dec == 7'd0) begin
          lit_run_nxt = 1'b0;
        end
      end else if (in_tdata == '0) begin
        q_push    = 1'b1;
        q_op.kind = OP_END_ROW;
      end else if (in_tdata[CODE_W-1]) begin
        // skip distance is the magnitude; -128 wraps to 128 as unsigned
        q_push    = 1'b1;
        q_op.kind = OP_SKIP;
        q_op.data = ~in_tdata + 8'd1;
      end else begin
        lit_run_nxt = 1'b1;
        left_nxt    = in_tdata[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_run_r <= 1'b0;
      left_r    <= 7'd0;
    end else begin
      lit_run_r <= lit_run_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

// ===== src/srle_fifo.sv =====
module srle_fifo import srle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output op_t  pop_op
);

  localparam int DEPTH = SRLE_FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // Advance pointers with wrap and track fill
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== src/srle_back.sv =====
module srle_back import srle_pkg::*; #(
  parameter int MAX_DIM = SRLE_MAX_DIM
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_wr_t          cfg,
  input  logic             op_valid,
  input  op_t              op,
  output logic             op_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic [0:0]       out_tuser
);

  localparam int COL_MAX = 2 * MAX_DIM + 1;
  localparam int COL_W   = $clog2(COL_MAX + 1);
  localparam int CMP_W   = (COL_W > DIM_W) ? COL_W : DIM_W;
  localparam int SUM_W   = ((COL_W > CODE_W) ? COL_W : CODE_W) + 1;

  logic [DIM_W-1:0] width_r, height_r;
  logic [COL_W-1:0] column_r, column_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic             vld_r, vld_nxt;
  logic             pix_r, pix_nxt;
  logic             done_r, done_nxt;
  logic [DIM_W-1:0] x_r, x_nxt;
  logic [DIM_W-1:0] y_r, y_nxt;
  logic [PIX_W-1:0] val_r, val_nxt;

  logic [CODE_W-1:0] step;
  logic [SUM_W-1:0]  col_sum;
  logic [COL_W-1:0]  col_sat;
  logic [CMP_W-1:0]  col_ext;
  logic [DIM_W:0]    row_inc;
  logic              do_op;

  // Take a new op whenever the output register is free or draining
  assign op_pop = op_valid && (!vld_r || out_tready);
  assign do_op  = op_pop;

  // Saturating column advance
  assign step    = (op.kind == OP_LITERAL) ? CODE_W'(1) : op.data;
  assign col_sum = SUM_W'(column_r) + SUM_W'(step);
  assign col_sat = (col_sum > SUM_W'(COL_MAX)) ? COL_W'(COL_MAX) : col_sum[COL_W-1:0];
  assign col_ext = CMP_W'(column_r);
  assign row_inc = {1'b0, row_r} + (DIM_W + 1)'(1);

  // Execute op and load the output register
  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    vld_nxt    = vld_r && !out_tready;
    pix_nxt    = pix_r;
    done_nxt   = done_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    val_nxt    = val_r;
    if (do_op) begin
      case (op.kind)
        OP_LITERAL: begin
          if (col_ext < CMP_W'(width_r)) begin
            vld_nxt  = 1'b1;
            pix_nxt  = 1'b1;
            done_nxt = 1'b0;
            x_nxt    = col_ext[DIM_W-1:0];
            y_nxt    = row_r;
            val_nxt  = op.data;
          end
          column_nxt = col_sat;
        end
        OP_END_ROW: begin
          column_nxt = '0;
          if (row_inc >= {1'b0, height_r}) begin
            row_nxt  = '0;
            vld_nxt  = 1'b1;
            pix_nxt  = 1'b0;
            done_nxt = 1'b1;
            x_nxt    = '0;
            y_nxt    = '0;
            val_nxt  = '0;
          end else begin
            row_nxt = row_inc[DIM_W-1:0];
          end
        end
        OP_SKIP: begin
          column_nxt = col_sat;
        end
        default: begin
          column_nxt = column_r;
        end
      endcase
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SPRITE_WIDTH_RST;
      height_r <= SPRITE_HEIGHT_RST;
      column_r <= '0;
      row_r    <= '0;
      vld_r    <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == CFG_SPRITE_WIDTH) begin
        width_r <= cfg.data;
      end
      if (cfg.we && cfg.index == CFG_SPRITE_HEIGHT) begin
        height_r <= cfg.data;
      end
      column_r <= column_nxt;
      row_r    <= row_nxt;
      vld_r    <= vld_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pix_r  <= pix_nxt;
    done_r <= done_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    val_r  <= val_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {4'd0, val_r, y_r, x_r};
  assign out_tlast  = done_r;
  assign out_tuser  = pix_r;

endmodule
